>>> hw/rtl/lgrs_pkg.sv
// shared types, constants and cell functions for the life row stencil
package lgrs_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int ROW_BITS    = 64;
    localparam int CFG_BITS    = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_BITS-1:0] COLUMNS_RESET = CFG_BITS'(MAX_COLUMNS);

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic REG_COLUMNS_IN_USE = 1'b0;

    typedef struct packed {
        logic [ROW_BITS-1:0] above;
        logic [ROW_BITS-1:0] middle;
        logic [ROW_BITS-1:0] incoming;
        logic                held;
        logic                is_final;
    } lgrs_entry_t;

    typedef enum logic {
        PHASE_HELD,
        PHASE_FLUSH
    } lgrs_phase_t;

    function automatic logic [ROW_BITS-1:0] column_mask(input logic [CFG_BITS-1:0] n);
        logic [CFG_BITS-1:0] sat;
        logic [ROW_BITS-1:0] m;
        sat = (int'(n) > MAX_COLUMNS) ? CFG_BITS'(MAX_COLUMNS) : n;
        for (int c = 0; c < ROW_BITS; c++)
        begin
            m[c] = (c < int'(sat));
        end
        return m;
    endfunction

    function automatic logic [ROW_BITS-1:0] life_next(
        input logic [ROW_BITS-1:0] up,
        input logic [ROW_BITS-1:0] mid,
        input logic [ROW_BITS-1:0] down,
        input logic [ROW_BITS-1:0] mask
    );
        logic [3:0]          count;
        logic [ROW_BITS-1:0] r;
        for (int c = 0; c < ROW_BITS; c++)
        begin
            count = 4'(up[c]) + 4'(down[c]);
            if (c > 0)
            begin
                count = count + 4'(up[c-1]) + 4'(mid[c-1]) + 4'(down[c-1]);
            end
            if (c < ROW_BITS - 1)
            begin
                count = count + 4'(up[c+1]) + 4'(mid[c+1]) + 4'(down[c+1]);
            end
            r[c] = (count == 4'd3) || (mid[c] && (count == 4'd2));
        end
        return r & mask;
    endfunction

endpackage

>>> hw/rtl/lgrs_front.sv
// front end: takes rows, keeps the two latest rows, queues stencil work
module lgrs_front
    import lgrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                row_valid,
    input  logic                row_stall,
    input  logic [ROW_BITS-1:0] row_cells,
    input  logic                final_row,
    input  logic [ROW_BITS-1:0] mask,
    output logic                push,
    output lgrs_entry_t         push_entry
);

    logic [ROW_BITS-1:0] above_reg;
    logic [ROW_BITS-1:0] above_next;
    logic [ROW_BITS-1:0] middle_reg;
    logic [ROW_BITS-1:0] middle_next;
    logic                held_reg;
    logic                held_next;
    logic                accept;
    logic [ROW_BITS-1:0] incoming;

    assign accept   = row_valid && !row_stall;
    assign incoming = row_cells & mask;
    assign push     = accept && (held_reg || final_row);

    always_comb
    begin
        push_entry.above    = above_reg;
        push_entry.middle   = middle_reg;
        push_entry.incoming = incoming;
        push_entry.held     = held_reg;
        push_entry.is_final = final_row;
    end

    always_comb
    begin
        above_next  = above_reg;
        middle_next = middle_reg;
        held_next   = held_reg;
        if (accept)
        begin
            if (final_row)
            begin
                above_next  = '0;
                middle_next = '0;
                held_next   = 1'b0;
            end
            else
            begin
                above_next  = held_reg ? middle_reg : '0;
                middle_next = incoming;
                held_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg  <= '0;
            middle_reg <= '0;
            held_reg   <= 1'b0;
        end
        else
        begin
            above_reg  <= above_next;
            middle_reg <= middle_next;
            held_reg   <= held_next;
        end
    end

endmodule

>>> hw/rtl/lgrs_queue.sv
// short work queue between front end and back end
module lgrs_queue
    import lgrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  lgrs_entry_t push_entry,
    input  logic        pop,
    output logic        full,
    output logic        head_valid,
    output lgrs_entry_t head_entry
);

    lgrs_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full       = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/lgrs_back.sv
// back end: runs the cell stencil and drives the result register
module lgrs_back
    import lgrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  lgrs_entry_t         head_entry,
    input  logic [ROW_BITS-1:0] mask,
    output logic                pop,
    input  logic                result_stall,
    output logic                result_valid,
    output logic [ROW_BITS-1:0] next_cells,
    output logic                last_of_run,
    output logic                generation_done
);

    lgrs_phase_t         phase_reg;
    lgrs_phase_t         phase_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [ROW_BITS-1:0] cells_reg;
    logic                last_reg;
    logic                done_reg;
    logic                can_load;
    logic                load;
    logic [ROW_BITS-1:0] sel_up;
    logic [ROW_BITS-1:0] sel_mid;
    logic [ROW_BITS-1:0] sel_down;
    logic                sel_last;
    logic                sel_done;
    logic [ROW_BITS-1:0] stencil;

    assign can_load = !out_valid_reg || !result_stall;

    always_comb
    begin
        phase_next = phase_reg;
        load       = 1'b0;
        pop        = 1'b0;
        if ((phase_reg == PHASE_HELD) && head_entry.held)
        begin
            sel_up   = head_entry.above;
            sel_mid  = head_entry.middle;
            sel_down = head_entry.incoming;
            sel_last = !head_entry.is_final;
            sel_done = 1'b0;
        end
        else
        begin
            sel_up   = head_entry.held ? head_entry.middle : '0;
            sel_mid  = head_entry.incoming;
            sel_down = '0;
            sel_last = 1'b1;
            sel_done = 1'b1;
        end
        if (head_valid && can_load)
        begin
            load = 1'b1;
            case (phase_reg)
                PHASE_HELD:
                begin
                    if (head_entry.held && head_entry.is_final)
                    begin
                        phase_next = PHASE_FLUSH;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                PHASE_FLUSH:
                begin
                    pop        = 1'b1;
                    phase_next = PHASE_HELD;
                end
                default:
                begin
                    phase_next = PHASE_HELD;
                end
            endcase
        end
        out_valid_next = can_load ? load : out_valid_reg;
    end

    assign stencil = life_next(sel_up, sel_mid, sel_down, mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_HELD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cells_reg <= stencil;
            last_reg  <= sel_last;
            done_reg  <= sel_done;
        end
    end

    assign result_valid    = out_valid_reg;
    assign next_cells      = cells_reg;
    assign last_of_run     = last_reg;
    assign generation_done = done_reg;

endmodule

>>> hw/rtl/life_generation_row_stencil.sv
// top level of the streaming life generation row stencil
//
//  channel   | handshake               | payload
//  row in    | row_valid / row_stall   | row_cells, final_row
//  result    | result_valid / result_stall | next_cells, last_of_run, generation_done
//  config    | psel / penable / pready | paddr, pwdata, prdata
//
// one row is taken per cycle unless stalled; work is queued, results are registered
// a bottom row with a row held gives two results, one after the other from the
// single result register in the back end
// reset clears the held rows, empties the queue and drops result_valid at once
// result_stall fills the two-entry work queue, which then raises row_stall
module life_generation_row_stencil
    import lgrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     row_valid,
    output logic                     row_stall,
    input  logic [ROW_BITS-1:0]      row_cells,
    input  logic                     final_row,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [ROW_BITS-1:0]      next_cells,
    output logic                     last_of_run,
    output logic                     generation_done,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [CFG_BITS-1:0] columns_reg;
    logic [CFG_BITS-1:0] columns_next;
    logic [ROW_BITS-1:0] mask;
    logic                push;
    lgrs_entry_t         push_entry;
    logic                pop;
    logic                full;
    logic                head_valid;
    lgrs_entry_t         head_entry;

    assign pready = 1'b1;

    always_comb
    begin
        columns_next = columns_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_COLUMNS_IN_USE))
        begin
            columns_next = pwdata[CFG_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_COLUMNS_IN_USE)
        begin
            prdata = APB_DATA_BITS'(columns_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
        end
        else
        begin
            columns_reg <= columns_next;
        end
    end

    assign mask      = column_mask(columns_reg);
    assign row_stall = full;

    lgrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_valid  (row_valid),
        .row_stall  (row_stall),
        .row_cells  (row_cells),
        .final_row  (final_row),
        .mask       (mask),
        .push       (push),
        .push_entry (push_entry)
    );

    lgrs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    lgrs_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_entry      (head_entry),
        .mask            (mask),
        .pop             (pop),
        .result_stall    (result_stall),
        .result_valid    (result_valid),
        .next_cells      (next_cells),
        .last_of_run     (last_of_run),
        .generation_done (generation_done)
    );

endmodule

>>> hw/rtl/lgrs_checker.sv
// port-level checks for the life row stencil, bound to the top level
module lgrs_checker
    import lgrs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     result_valid,
    input logic                     result_stall,
    input logic [ROW_BITS-1:0]      next_cells,
    input logic                     last_of_run,
    input logic                     generation_done
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(next_cells)
            && $stable(last_of_run) && $stable(generation_done))
    else $error("result changed while stalled");

    // bottom row always closes the run of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && generation_done |-> last_of_run)
    else $error("generation end without end of run");

    // a run left open is closed by the bottom row in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !last_of_run |=> result_valid && generation_done)
    else $error("bottom row did not follow an open run");

endmodule

bind life_generation_row_stencil lgrs_checker u_lgrs_checker (.*);

>>> tb/sv/life_generation_row_stencil_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the streaming life generation row stencil
module life_generation_row_stencil_tb;
    import lgrs_pkg::*;

    typedef struct packed {
        logic [ROW_BITS-1:0] cells;
        logic                last_of_run;
        logic                generation_done;
    } life_result_t;

    localparam logic [APB_ADDR_BITS-1:0] ADDR_COLUMNS  = APB_ADDR_BITS'(4 * REG_COLUMNS_IN_USE);
    localparam logic [APB_ADDR_BITS-1:0] ADDR_UNMAPPED = ADDR_COLUMNS + APB_ADDR_BITS'(4);

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     row_valid;
    logic                     row_stall;
    logic [ROW_BITS-1:0]      row_cells;
    logic                     final_row;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic [ROW_BITS-1:0]      next_cells;
    logic                     last_of_run;
    logic                     generation_done;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // predictor state
    logic [ROW_BITS-1:0] grid_above;
    logic [ROW_BITS-1:0] grid_middle;
    logic                middle_held;
    logic [CFG_BITS-1:0] columns_cfg;

    life_result_t pending_rows[$];
    int unsigned  mismatches;
    int unsigned  send_idle_pct;
    int unsigned  recv_idle_pct;

    life_generation_row_stencil i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .row_valid       (row_valid),
        .row_stall       (row_stall),
        .row_cells       (row_cells),
        .final_row       (final_row),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .next_cells      (next_cells),
        .last_of_run     (last_of_run),
        .generation_done (generation_done),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [ROW_BITS-1:0] live_mask(input logic [CFG_BITS-1:0] n);
        if (n >= CFG_BITS'(MAX_COLUMNS))
        begin
            return '1;
        end
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic logic [ROW_BITS-1:0] life_rule(
        input logic [ROW_BITS-1:0] up,
        input logic [ROW_BITS-1:0] mid,
        input logic [ROW_BITS-1:0] down
    );
        logic [ROW_BITS+1:0] u;
        logic [ROW_BITS+1:0] m;
        logic [ROW_BITS+1:0] d;
        int unsigned         n;
        logic [ROW_BITS-1:0] r;
        u = {1'b0, up, 1'b0};
        m = {1'b0, mid, 1'b0};
        d = {1'b0, down, 1'b0};
        for (int c = 0; c < ROW_BITS; c++)
        begin
            n = int'(u[c]) + int'(u[c+1]) + int'(u[c+2]) + int'(m[c]) + int'(m[c+2])
              + int'(d[c]) + int'(d[c+1]) + int'(d[c+2]);
            r[c] = (n == 3) || (m[c+1] && n == 2);
        end
        return r;
    endfunction

    function automatic void predict_row(input logic [ROW_BITS-1:0] cells, input logic fin);
        logic [ROW_BITS-1:0] msk;
        logic [ROW_BITS-1:0] incoming;
        msk = live_mask(columns_cfg);
        incoming = cells & msk;
        if (middle_held)
        begin
            pending_rows.push_back('{life_rule(grid_above, grid_middle, incoming) & msk,
                                     !fin, 1'b0});
            grid_above = grid_middle;
        end
        else
        begin
            grid_above = '0;
        end
        grid_middle = incoming;
        middle_held = 1'b1;
        if (fin)
        begin
            pending_rows.push_back('{life_rule(grid_above, grid_middle, '0) & msk, 1'b1, 1'b1});
            grid_above = '0;
            grid_middle = '0;
            middle_held = 1'b0;
        end
    endfunction

    function automatic logic [ROW_BITS-1:0] random_row();
        logic [ROW_BITS-1:0] a;
        logic [ROW_BITS-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return a & b & {$urandom, $urandom};
            3:       return a | b;
            4:       return 64'd1 << $urandom_range(63);
            default: return a;
        endcase
    endfunction

    task automatic send_row(input logic [ROW_BITS-1:0] cells, input logic fin);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            row_valid = 1'b0;
            @(negedge clk);
        end
        row_valid = 1'b1;
        row_cells = cells;
        final_row = fin;
        do
            @(posedge clk);
        while (row_stall);
        predict_row(cells, fin);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        row_valid = 1'b0;
        while (pending_rows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_BITS-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_COLUMNS)
        begin
            columns_cfg = data[CFG_BITS-1:0];
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_columns_reg();
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_COLUMNS;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== APB_DATA_BITS'(columns_cfg))
        begin
            $display("%0t: columns_in_use read: expected %0d, actual %0d",
                     $time, columns_cfg, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    always @(posedge clk)
    begin
        life_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_rows.size() == 0)
            begin
                $display("%0t: unexpected transfer: expected none, actual %h %b %b",
                         $time, next_cells, last_of_run, generation_done);
                mismatches++;
            end
            else
            begin
                want = pending_rows.pop_front();
                if (next_cells !== want.cells)
                begin
                    $display("%0t: next_cells: expected %h, actual %h",
                             $time, want.cells, next_cells);
                    mismatches++;
                end
                if (last_of_run !== want.last_of_run)
                begin
                    $display("%0t: last_of_run: expected %b, actual %b",
                             $time, want.last_of_run, last_of_run);
                    mismatches++;
                end
                if (generation_done !== want.generation_done)
                begin
                    $display("%0t: generation_done: expected %b, actual %b",
                             $time, want.generation_done, generation_done);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_directed_rows();
        // single-row generations
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        send_row(64'h8000_0000_0000_0001, 1'b1);
        // blinker
        send_row('0, 1'b0);
        send_row(64'h38, 1'b0);
        send_row('0, 1'b1);
        // blocks on both edge columns
        send_row(64'hC000_0000_0000_0003, 1'b0);
        send_row(64'hC000_0000_0000_0003, 1'b0);
        send_row(64'h0, 1'b1);
        // checkerboard
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        // glider
        send_row(64'h2, 1'b0);
        send_row(64'h4, 1'b0);
        send_row(64'h7, 1'b1);
        // full rows, then two random rows
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        send_row({$urandom, $urandom}, 1'b0);
        send_row({$urandom, $urandom}, 1'b1);
    endtask

    task automatic test_column_counts();
        logic [CFG_BITS-1:0] counts[8];
        counts = '{7'd0, 7'd1, 7'd2, 7'd63, 7'd65, 7'd127, 7'd37, 7'd64};
        foreach (counts[k])
        begin
            wait_for_results();
            write_reg(ADDR_COLUMNS, 32'(counts[k]));
            check_columns_reg();
            send_row('1, 1'b0);
            send_row(random_row(), 1'b0);
            send_row({$urandom, $urandom}, 1'b0);
            send_row('1, 1'b1);
        end
        // write to an unmapped address leaves the count alone
        wait_for_results();
        write_reg(ADDR_UNMAPPED, $urandom);
        check_columns_reg();
        // count change with a row held between transfers
        send_row({$urandom, $urandom}, 1'b0);
        send_row({$urandom, $urandom}, 1'b0);
        wait_for_results();
        write_reg(ADDR_COLUMNS, 32'd20);
        send_row('1, 1'b0);
        send_row({$urandom, $urandom}, 1'b1);
        wait_for_results();
        write_reg(ADDR_COLUMNS, 32'd64);
    endtask

    task automatic test_random_rows(input int unsigned snd_pct, input int unsigned rcv_pct,
                                    input logic [CFG_BITS-1:0] cols, input int unsigned rows);
        int unsigned sent;
        int unsigned len;
        wait_for_results();
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        write_reg(ADDR_COLUMNS, 32'(cols));
        sent = 0;
        while (sent < rows)
        begin
            case ($urandom_range(9))
                0:       len = 1;
                1, 2:    len = $urandom_range(7, 24);
                default: len = $urandom_range(2, 6);
            endcase
            for (int i = 0; i < len; i++)
            begin
                send_row(random_row(), i == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        row_valid = 1'b0;
        row_cells = '0;
        final_row = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        grid_above = '0;
        grid_middle = '0;
        middle_held = 1'b0;
        columns_cfg = COLUMNS_RESET;
        mismatches = 0;
        send_idle_pct = 25;
        recv_idle_pct = 46;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_rows();
        test_column_counts();
        test_random_rows(25, 46, 7'd64, 600);
        test_random_rows(46, 25, CFG_BITS'($urandom_range(3, 63)), 600);
        test_random_rows(0, 0, 7'd64, 600);
        wait_for_results();
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/lgrs_pkg.sv
hw/rtl/lgrs_front.sv
hw/rtl/lgrs_queue.sv
hw/rtl/lgrs_back.sv
hw/rtl/life_generation_row_stencil.sv
hw/rtl/lgrs_checker.sv
tb/sv/life_generation_row_stencil_tb.sv
